// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define KKSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define KKSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/kksr_pkg.sv
`default_nettype none

package kksr_pkg;

  localparam logic [2:0] REQ_KEY   = 3'd0;
  localparam logic [2:0] REQ_INIT  = 3'd1;
  localparam logic [2:0] REQ_OPEN  = 3'd2;
  localparam logic [2:0] REQ_CLOSE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [3:0] SESSION_HANDLE = 4'd1;
  localparam int         FIRST_CODE     = 4;
  localparam int         COUNT_W        = 6;

  typedef struct packed {
    logic [2:0] locks;
    logic [7:0] mods;
  } kksr_flags_t;

  // Host word bits lctrl 6, lshift 0, lalt 8, lmeta 10, rctrl 7, rshift 1,
  // ralt 9, rmeta 11 land on modifier bits 0 through 7.
  function automatic logic [7:0] pack_mods(input logic [15:0] w);
    return {w[11], w[9], w[1], w[7], w[10], w[8], w[0], w[6]};
  endfunction

  // Num lock is bit 12, caps lock bit 13 and scroll lock bit 15.
  function automatic logic [2:0] pack_locks(input logic [15:0] w);
    return {w[15], w[13], w[12]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/keyboard_key_state_reporter.sv
// Keyboard key state reporter. A request is taken when start is high and
// busy is low. Key event, init, open and close requests, and any rejected
// request, give one status result on the cycle after the transfer and keep
// busy low, so a new request can follow every cycle. A read in an open
// session walks the key table through its single read port, one entry per
// cycle from usage code 4, and keeps busy high through the scan and summary
// (the scan ends early once MAX_REPORTED_KEYS pressed keys are found); it
// emits one result per pressed key and then the summary with last set.
// After reset the key table is cleared one entry per cycle, and busy stays
// high until every entry is clear. Results are shown for exactly one cycle
// with out_valid high and cannot be stalled by the receiver.
`default_nettype none
`include "assert_macros.svh"

module keyboard_key_state_reporter
  import kksr_pkg::*;
#(
  parameter int MAX_REPORTED_KEYS = 32,
  parameter int KEY_SLOTS         = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_req_type,
  input  wire logic signed [9:0] in_usage_code,
  input  wire logic              in_key_down,
  input  wire logic [15:0]       in_modifier_flags,
  input  wire logic [3:0]        in_handle,
  input  wire logic [31:0]       in_timestamp,
  output logic                   out_valid,
  output logic                   out_status,
  output logic                   out_kind,
  output logic [7:0]             out_keycode,
  output logic [COUNT_W-1:0]     out_key_count,
  output logic [2:0]             out_lock_bits,
  output logic [7:0]             out_modifier_bits,
  output logic [31:0]            out_report_time,
  output logic                   out_last
);

  localparam int AW = $clog2(KEY_SLOTS);

  kksr_flags_t   flags_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          mem_wd;
  logic [AW-1:0] mem_ra;
  logic          mem_rd;

  // Modifier and lock state follow every key event, in or out of range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (start && !busy && (in_req_type == REQ_KEY)) begin
      flags_r.locks <= pack_locks(in_modifier_flags);
      flags_r.mods  <= pack_mods(in_modifier_flags);
    end
  end

  kksr_ctrl #(
    .KEY_SLOTS         (KEY_SLOTS),
    .MAX_REPORTED_KEYS (MAX_REPORTED_KEYS),
    .AW                (AW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_usage_code     (in_usage_code),
    .in_key_down       (in_key_down),
    .in_handle         (in_handle),
    .in_timestamp      (in_timestamp),
    .flags             (flags_r),
    .mem_we            (mem_we),
    .mem_wa            (mem_wa),
    .mem_wd            (mem_wd),
    .mem_ra            (mem_ra),
    .mem_rd            (mem_rd),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_kind          (out_kind),
    .out_keycode       (out_keycode),
    .out_key_count     (out_key_count),
    .out_lock_bits     (out_lock_bits),
    .out_modifier_bits (out_modifier_bits),
    .out_report_time   (out_report_time),
    .out_last          (out_last)
  );

  kksr_keymap #(
    .DEPTH (KEY_SLOTS),
    .AW    (AW)
  ) u_keymap (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  `KKSR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (busy && !out_valid), "reset must clear and block")
  `KKSR_ASSERT(a_status_next, (start && !busy && in_req_type != REQ_READ) |=> (out_valid && out_last), "status result missing after transfer")
  `KKSR_ASSERT(a_keycode_in_read, (out_valid && out_kind) |-> (busy && !out_last), "keycode result outside a read")
  `KKSR_ASSERT(a_count_limit, out_valid |-> (32'(out_key_count) <= MAX_REPORTED_KEYS), "key count above limit")

endmodule

`default_nettype wire

// File: rtl/kksr_keymap.sv
`default_nettype none

module kksr_keymap #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic          wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic               rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/kksr_ctrl.sv
`default_nettype none

module kksr_ctrl
  import kksr_pkg::*;
#(
  parameter int KEY_SLOTS         = 256,
  parameter int MAX_REPORTED_KEYS = 32,
  parameter int AW                = $clog2(KEY_SLOTS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_req_type,
  input  wire logic signed [9:0] in_usage_code,
  input  wire logic              in_key_down,
  input  wire logic [3:0]        in_handle,
  input  wire logic [31:0]       in_timestamp,
  input  wire kksr_flags_t       flags,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_wa,
  output logic                   mem_wd,
  output logic [AW-1:0]          mem_ra,
  input  wire logic              mem_rd,
  output logic                   out_valid,
  output logic                   out_status,
  output logic                   out_kind,
  output logic [7:0]             out_keycode,
  output logic [COUNT_W-1:0]     out_key_count,
  output logic [2:0]             out_lock_bits,
  output logic [7:0]             out_modifier_bits,
  output logic [31:0]            out_report_time,
  output logic                   out_last
);

  localparam int CW = $clog2(KEY_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SUM
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      addr_r;
  logic               pend_r;
  logic [7:0]         pend_code_r;
  logic [COUNT_W-1:0] count_r;
  logic [31:0]        time_r;
  logic               ready_r;
  logic               open_r;

  logic               out_valid_r;
  logic               out_status_r;
  logic               out_kind_r;
  logic [7:0]         out_keycode_r;
  logic [COUNT_W-1:0] out_key_count_r;
  logic [2:0]         out_lock_bits_r;
  logic [7:0]         out_modifier_bits_r;
  logic [31:0]        out_report_time_r;
  logic               out_last_r;

  logic               accept;
  logic               session_ok;
  logic               rej;
  logic [9:0]         code_u;
  logic               key_in_range;
  logic               issue;
  logic               hit;
  logic [COUNT_W-1:0] count_nxt;
  logic               scan_done;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && (state_r == ST_IDLE);
  assign session_ok = (in_handle == SESSION_HANDLE) && open_r;

  assign code_u       = {1'b0, in_usage_code[8:0]};
  assign key_in_range = !in_usage_code[9] && (32'(code_u) < KEY_SLOTS);

  // The read port runs one entry ahead of the compare: pend_r marks that
  // mem_rd holds the entry at pend_code_r.
  assign issue     = (32'(addr_r) < KEY_SLOTS);
  assign hit       = pend_r && mem_rd;
  assign count_nxt = count_r + COUNT_W'(hit);
  assign scan_done = !issue || (32'(count_nxt) == MAX_REPORTED_KEYS);

  always_comb begin
    unique case (in_req_type)
      REQ_KEY:   rej = 1'b0;
      REQ_INIT:  rej = 1'b0;
      REQ_OPEN:  rej = !ready_r || open_r;
      REQ_CLOSE: rej = !session_ok;
      REQ_READ:  rej = !session_ok;
      default:   rej = 1'b1;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r[AW-1:0];
    mem_wd = 1'b0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && (in_req_type == REQ_KEY) && key_in_range) begin
      mem_we = 1'b1;
      mem_wa = AW'(code_u);
      mem_wd = in_key_down;
    end
  end

  assign mem_ra = addr_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      ready_r     <= 1'b0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          out_valid_r <= 1'b0;
          addr_r      <= addr_r + 1'b1;
          if (addr_r == CW'(KEY_SLOTS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          // Every transfer but an accepted read answers with one status result.
          out_valid_r <= accept && !((in_req_type == REQ_READ) && !rej);
          if (accept) begin
            if ((in_req_type == REQ_READ) && !rej) begin
              state_r <= ST_SCAN;
              addr_r  <= CW'(FIRST_CODE);
              pend_r  <= 1'b0;
              count_r <= '0;
              time_r  <= in_timestamp;
            end else begin
              if (in_req_type == REQ_INIT) begin
                ready_r <= 1'b1;
              end
              if ((in_req_type == REQ_OPEN) && !rej) begin
                open_r <= 1'b1;
              end
              if ((in_req_type == REQ_CLOSE) && !rej) begin
                open_r <= 1'b0;
              end
              out_status_r        <= rej;
              out_kind_r          <= 1'b0;
              out_keycode_r       <= '0;
              out_key_count_r     <= '0;
              out_lock_bits_r     <= '0;
              out_modifier_bits_r <= '0;
              out_report_time_r   <= '0;
              out_last_r          <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          out_valid_r <= hit;
          addr_r      <= addr_r + 1'b1;
          pend_r      <= issue && !scan_done;
          pend_code_r <= 8'(addr_r);
          count_r     <= count_nxt;
          if (hit) begin
            out_status_r        <= 1'b0;
            out_kind_r          <= 1'b1;
            out_keycode_r       <= pend_code_r;
            out_key_count_r     <= '0;
            out_lock_bits_r     <= '0;
            out_modifier_bits_r <= '0;
            out_report_time_r   <= '0;
            out_last_r          <= 1'b0;
          end
          if (scan_done) begin
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          state_r             <= ST_IDLE;
          out_valid_r         <= 1'b1;
          out_status_r        <= 1'b0;
          out_kind_r          <= 1'b0;
          out_keycode_r       <= '0;
          out_key_count_r     <= count_r;
          out_lock_bits_r     <= flags.locks;
          out_modifier_bits_r <= flags.mods;
          out_report_time_r   <= time_r;
          out_last_r          <= 1'b1;
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_kind          = out_kind_r;
  assign out_keycode       = out_keycode_r;
  assign out_key_count     = out_key_count_r;
  assign out_lock_bits     = out_lock_bits_r;
  assign out_modifier_bits = out_modifier_bits_r;
  assign out_report_time   = out_report_time_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire
